// ===== rtl/core/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg
// Shared constants, codes and the quarter-wave sine ROM of the sequencer.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int SINE_ENTRIES = 256;
    localparam int SINE_BITS    = 16;
    localparam int PHASE_BITS   = 32;

    localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
    localparam int QUAD_BITS    = PHASE_BITS - 2;
    localparam int ROUND_SHIFT  = 31 - SINE_BITS;
    localparam int ANGLE_W      = 11;
    localparam int ELAPSED_W    = 26;

    localparam logic [SINE_BITS-2:0] SINE_FULL = {(SINE_BITS-1){1'b1}};
    localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

    // Machine states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHAKE = 2'd1;
    localparam logic [1:0] ST_REST  = 2'd2;
    localparam logic [1:0] ST_TUNE  = 2'd3;

    // Command codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_TUNE   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_TARGET = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_CENTER    = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE = 3'd1;
    localparam logic [2:0] REG_PHASE     = 3'd2;
    localparam logic [2:0] REG_SHAKE     = 3'd3;
    localparam logic [2:0] REG_REST      = 3'd4;
    localparam logic [2:0] REG_TUNE      = 3'd5;

    // Last sine sign seen
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [7:0] ANGLE_MAX = 8'd180;

    typedef logic [SINE_BITS-2:0] sine_rom_t [SINE_ENTRIES];

    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    // Q30 Taylor series of sin, rounded half up to the table format
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
                if (k % 2 == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            v = (unsigned'(sum) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (v > 64'(SINE_FULL))
            begin
                v = 64'(SINE_FULL);
            end
            rom[i] = v[SINE_BITS-2:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/sos_angle.sv =====
// ----------------------------------------------------------------------------
// sos_angle
// Sine lookup of the phase and the clamped servo angle it gives.
// ----------------------------------------------------------------------------
module sos_angle
    import sos_pkg::*;
(
    input  logic [PHASE_BITS-1:0] phase,
    input  logic [7:0]            center,
    input  logic [7:0]            amplitude,
    output logic [7:0]            angle,
    output logic                  negative
);

    logic [1:0]                  quad;
    logic [IDX_BITS-1:0]         idx;
    logic [IDX_BITS-1:0]         addr;
    logic                        full;
    logic [SINE_BITS-2:0]        mag;
    logic signed [SINE_BITS-1:0] sine;
    logic signed [SINE_BITS+8:0] prod;
    logic signed [ANGLE_W-1:0]   offset;
    logic signed [ANGLE_W-1:0]   sum;

    always_comb
    begin
        quad = phase[PHASE_BITS-1 -: 2];
        idx  = phase[QUAD_BITS-1 -: IDX_BITS];
        // odd quadrants run the table backwards; index zero there is full scale
        if (quad[0])
        begin
            addr = IDX_BITS'(~idx + 1'b1);
            full = (idx == '0);
        end
        else
        begin
            addr = idx;
            full = 1'b0;
        end
        mag  = full ? SINE_FULL : SINE_ROM[addr];
        sine = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        negative = quad[1] && (mag != '0);

        prod   = signed'({1'b0, amplitude}) * sine;
        // arithmetic shift floors towards minus infinity
        offset = ANGLE_W'(prod >>> (SINE_BITS - 1));
        sum    = signed'(ANGLE_W'({1'b0, center})) + offset;

        if (sum < 0)
        begin
            angle = 8'd0;
        end
        else if (sum > signed'(ANGLE_W'(ANGLE_MAX)))
        begin
            angle = ANGLE_MAX;
        end
        else
        begin
            angle = sum[7:0];
        end
    end

endmodule

// ===== rtl/core/servo_oscillation_sequencer.sv =====
// ----------------------------------------------------------------------------
// servo_oscillation_sequencer
// Idle / shaking / resting / tuning sequencer driven by ms ticks and commands.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_stall  mode, target_angle
//  out      out_valid/out_stall state_code, servo_angle, servo_enabled,
//                              step_total, cycle_total
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One item per cycle while the result side does not stall. Each transfer
//  enters the input register at its edge; the state and result registers
//  take it when the result side advances. The state loop runs through the
//  phase add, sine ROM and amplitude multiply without a register.
//  Reset sets all but the command and result data registers; ROM is constant.
//  A stalled result holds the input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
module servo_oscillation_sequencer
    import sos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [15:0] target_angle,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         state_code,
    output logic [7:0]         servo_angle,
    output logic               servo_enabled,
    output logic [31:0]        step_total,
    output logic [31:0]        cycle_total,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // configuration
    logic [7:0]  center_reg;
    logic [7:0]  amplitude_reg;
    logic [31:0] phase_step_reg;
    logic [15:0] shake_sec_reg;
    logic [15:0] rest_sec_reg;
    logic [15:0] tune_ms_reg;

    // input stage
    logic               in_full_reg;
    logic [2:0]         mode_reg;
    logic signed [15:0] target_reg;

    // machine state
    logic [1:0]            state_reg,   state_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [PHASE_BITS-1:0] phase_reg,   phase_next;
    logic [1:0]            sign_reg,    sign_next;
    logic [31:0]           step_reg,    step_next;
    logic [31:0]           cycle_reg,   cycle_next;
    logic [7:0]            angle_reg,   angle_next;
    logic [7:0]            tpos_reg,    tpos_next;
    logic [7:0]            tgoal_reg,   tgoal_next;
    logic [15:0]           ttimer_reg,  ttimer_next;

    logic                  out_valid_reg;

    logic                  advance;
    logic                  fire;
    logic                  accept;
    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic [ELAPSED_W-1:0]  shake_limit;
    logic [ELAPSED_W-1:0]  rest_limit;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [15:0]           ttimer_inc;
    logic [7:0]            center_clamped;
    logic [7:0]            target_clamped;
    logic [7:0]            sine_angle;
    logic                  sine_negative;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_full_reg && advance;
    assign in_stall  = in_full_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign shake_limit = ELAPSED_W'(shake_sec_reg) * ELAPSED_W'(1000);
    assign rest_limit  = ELAPSED_W'(rest_sec_reg) * ELAPSED_W'(1000);
    assign phase_inc   = phase_reg + PHASE_BITS'(phase_step_reg);
    assign ttimer_inc  = (ttimer_reg != 16'hFFFF) ? ttimer_reg + 1'b1 : ttimer_reg;

    assign center_clamped = (center_reg > ANGLE_MAX) ? ANGLE_MAX : center_reg;
    assign target_clamped = (target_reg < 0) ? 8'd0 :
                            (target_reg > signed'(16'(ANGLE_MAX))) ? ANGLE_MAX :
                            target_reg[7:0];

    sos_angle u_angle
    (
        .phase     (phase_inc),
        .center    (center_reg),
        .amplitude (amplitude_reg),
        .angle     (sine_angle),
        .negative  (sine_negative)
    );

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        sign_next    = sign_reg;
        step_next    = step_reg;
        cycle_next   = cycle_reg;
        angle_next   = angle_reg;
        tpos_next    = tpos_reg;
        tgoal_next   = tgoal_reg;
        ttimer_next  = ttimer_reg;

        unique case (mode_reg)
            MODE_TICK:
            begin
                unique case (state_reg)
                    ST_SHAKE:
                    begin
                        phase_next = phase_inc;
                        if (elapsed_inc >= shake_limit)
                        begin
                            state_next   = ST_REST;
                            elapsed_next = '0;
                            angle_next   = center_clamped;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                            angle_next   = sine_angle;
                            sign_next    = sine_negative ? SIGN_NEG : SIGN_POS;
                            if (sign_reg == SIGN_NEG && !sine_negative)
                            begin
                                step_next = step_reg + 1'b1;
                            end
                        end
                    end
                    ST_REST:
                    begin
                        if (elapsed_inc >= rest_limit)
                        begin
                            state_next   = ST_SHAKE;
                            elapsed_next = '0;
                            phase_next   = '0;
                            sign_next    = SIGN_NONE;
                            cycle_next   = cycle_reg + 1'b1;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    ST_TUNE:
                    begin
                        ttimer_next = ttimer_inc;
                        if (tpos_reg != tgoal_reg && ttimer_inc >= tune_ms_reg)
                        begin
                            ttimer_next = '0;
                            tpos_next   = (tpos_reg < tgoal_reg) ? tpos_reg + 1'b1
                                                                 : tpos_reg - 1'b1;
                            angle_next  = tpos_next;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_START:
            begin
                state_next   = ST_SHAKE;
                elapsed_next = '0;
                phase_next   = '0;
                sign_next    = SIGN_NONE;
                cycle_next   = cycle_reg + 1'b1;
            end
            MODE_STOP:
            begin
                state_next = ST_IDLE;
                angle_next = center_clamped;
            end
            MODE_TUNE:
            begin
                state_next  = ST_TUNE;
                tpos_next   = angle_reg;
                tgoal_next  = angle_reg;
                ttimer_next = '0;
            end
            MODE_CLEAR:
            begin
                step_next  = '0;
                cycle_next = '0;
            end
            MODE_TARGET:
            begin
                if (state_reg == ST_TUNE)
                begin
                    tgoal_next = target_clamped;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= 8'd90;
            amplitude_reg  <= 8'd30;
            phase_step_reg <= 32'd12884902;
            shake_sec_reg  <= 16'd10;
            rest_sec_reg   <= 16'd60;
            tune_ms_reg    <= 16'd20;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER:    center_reg     <= cfg_data[7:0];
                REG_AMPLITUDE: amplitude_reg  <= cfg_data[7:0];
                REG_PHASE:     phase_step_reg <= cfg_data;
                REG_SHAKE:     shake_sec_reg  <= cfg_data[15:0];
                REG_REST:      rest_sec_reg   <= cfg_data[15:0];
                REG_TUNE:      tune_ms_reg    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            target_reg <= target_angle;
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            phase_reg   <= '0;
            sign_reg    <= SIGN_NONE;
            step_reg    <= '0;
            cycle_reg   <= '0;
            angle_reg   <= 8'd90;
            tpos_reg    <= 8'd90;
            tgoal_reg   <= 8'd90;
            ttimer_reg  <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            sign_reg    <= sign_next;
            step_reg    <= step_next;
            cycle_reg   <= cycle_next;
            angle_reg   <= angle_next;
            tpos_reg    <= tpos_next;
            tgoal_reg   <= tgoal_next;
            ttimer_reg  <= ttimer_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            state_code    <= state_next;
            servo_angle   <= angle_next;
            servo_enabled <= (state_next == ST_SHAKE) || (state_next == ST_TUNE);
            step_total    <= step_next;
            cycle_total   <= cycle_next;
        end
    end

endmodule

// ===== tb/sos_motion_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sos_motion_checker
// Watches the command, result and register channels of the sequencer, keeps
// its own model of the state machine, sine lookup and counters, and compares
// every result transfer against the oldest predicted report.
// ----------------------------------------------------------------------------
module sos_motion_checker
    import sos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [15:0] target_angle,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         state_code,
    input  logic [7:0]         servo_angle,
    input  logic               servo_enabled,
    input  logic [31:0]        step_total,
    input  logic [31:0]        cycle_total,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    output int                 reports_due,
    output int                 mismatch_count,
    output int                 results_checked,
    output logic [3:0]         states_seen,
    output logic [31:0]        peak_steps
);

    localparam int FULL_SCALE   = (1 << (SINE_BITS - 1)) - 1;
    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  angle;
        logic        enabled;
        logic [31:0] steps;
        logic [31:0] cycles;
    } motion_report_t;

    motion_report_t due_reports [$];

    int quarter_wave [SINE_ENTRIES];

    // register copies
    logic [7:0]            centre_deg;
    logic [7:0]            swing_deg;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [15:0]           shake_len_s;
    logic [15:0]           rest_len_s;
    logic [15:0]           slew_interval;

    // sequencer state
    logic [1:0]            seq_state;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [PHASE_BITS-1:0] phase;
    logic [1:0]            last_sign;
    logic [31:0]           steps;
    logic [31:0]           cycles;
    logic [7:0]            angle;
    logic [7:0]            tune_pos;
    logic [7:0]            tune_goal;
    logic [15:0]           tune_timer;

    // Q30 Taylor series, eight terms, rounded half up to the table format
    function automatic void fill_quarter_wave();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned divisor;
        longint unsigned rounded;
        longint          sum;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            ang    = (HALF_PI_Q30 * longint'(i)) / SINE_ENTRIES;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            sum    = longint'(ang);
            for (int k = 1; k <= 7; k++)
            begin
                divisor = longint'((2 * k) * (2 * k + 1));
                term    = ((term * ang_sq) >> 30) / divisor;
                if (k % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            rounded = (longint'(sum) + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (rounded > FULL_SCALE)
            begin
                rounded = FULL_SCALE;
            end
            quarter_wave[i] = int'(rounded);
        end
    endfunction

    function automatic void restore_defaults();
        centre_deg    = 8'd90;
        swing_deg     = 8'd30;
        phase_inc     = 32'd12884902;
        shake_len_s   = 16'd10;
        rest_len_s    = 16'd60;
        slew_interval = 16'd20;
        seq_state     = ST_IDLE;
        elapsed       = '0;
        phase         = '0;
        last_sign     = SIGN_NONE;
        steps         = '0;
        cycles        = '0;
        angle         = 8'd90;
        tune_pos      = 8'd90;
        tune_goal     = 8'd90;
        tune_timer    = '0;
    endfunction

    initial
    begin
        mismatch_count  = 0;
        results_checked = 0;
        reports_due     = 0;
        states_seen     = '0;
        peak_steps      = '0;
        fill_quarter_wave();
        restore_defaults();
    end

    function automatic logic [7:0] clamp_deg(input longint deg);
        if (deg < 0)
        begin
            return 8'd0;
        end
        if (deg > ANGLE_MAX)
        begin
            return ANGLE_MAX;
        end
        return 8'(deg);
    endfunction

    // signed sine sample, full-scale 2^(SINE_BITS-1)-1
    function automatic int sine_at(input logic [PHASE_BITS-1:0] ph);
        logic [1:0]      quad;
        longint unsigned slot;
        int              mag;
        quad = ph[PHASE_BITS-1 -: 2];
        slot = (64'(ph[QUAD_BITS-1:0]) * SINE_ENTRIES) >> QUAD_BITS;
        if (quad[0])
        begin
            slot = SINE_ENTRIES - slot;
        end
        if (slot >= SINE_ENTRIES)
        begin
            mag = FULL_SCALE;
        end
        else
        begin
            mag = quarter_wave[slot];
        end
        return quad[1] ? -mag : mag;
    endfunction

    function automatic void start_shaking();
        seq_state = ST_SHAKE;
        elapsed   = '0;
        phase     = '0;
        last_sign = SIGN_NONE;
        cycles    = cycles + 32'd1;
    endfunction

    function automatic void shake_tick();
        int         sample;
        longint     swing;
        logic [1:0] sign_now;
        if (elapsed != '1)
        begin
            elapsed = elapsed + 1'b1;
        end
        phase = phase + phase_inc;
        if (longint'(elapsed) >= longint'(shake_len_s) * 1000)
        begin
            seq_state = ST_REST;
            elapsed   = '0;
            angle     = clamp_deg(longint'(centre_deg));
            return;
        end
        sample = sine_at(phase);
        swing  = (longint'(swing_deg) * sample) >>> (SINE_BITS - 1);
        angle  = clamp_deg(longint'(centre_deg) + swing);
        sign_now = (sample >= 0) ? SIGN_POS : SIGN_NEG;
        if (last_sign == SIGN_NEG && sign_now == SIGN_POS)
        begin
            steps = steps + 32'd1;
        end
        last_sign = sign_now;
    endfunction

    function automatic void advance_sequencer(input logic [2:0]         cmd,
                                              input logic signed [15:0] goal);
        case (cmd)
            MODE_TICK:
            begin
                if (seq_state == ST_SHAKE)
                begin
                    shake_tick();
                end
                else if (seq_state == ST_REST)
                begin
                    if (elapsed != '1)
                    begin
                        elapsed = elapsed + 1'b1;
                    end
                    if (longint'(elapsed) >= longint'(rest_len_s) * 1000)
                    begin
                        start_shaking();
                    end
                end
                else if (seq_state == ST_TUNE)
                begin
                    if (tune_timer != 16'hFFFF)
                    begin
                        tune_timer = tune_timer + 16'd1;
                    end
                    if (tune_pos != tune_goal && tune_timer >= slew_interval)
                    begin
                        tune_timer = '0;
                        tune_pos   = (tune_pos < tune_goal) ? tune_pos + 8'd1
                                                            : tune_pos - 8'd1;
                        angle      = tune_pos;
                    end
                end
            end
            MODE_START:
            begin
                start_shaking();
            end
            MODE_STOP:
            begin
                seq_state = ST_IDLE;
                angle     = clamp_deg(longint'(centre_deg));
            end
            MODE_TUNE:
            begin
                seq_state  = ST_TUNE;
                tune_pos   = angle;
                tune_goal  = angle;
                tune_timer = '0;
            end
            MODE_CLEAR:
            begin
                steps  = '0;
                cycles = '0;
            end
            MODE_TARGET:
            begin
                if (seq_state == ST_TUNE)
                begin
                    tune_goal = clamp_deg(longint'(goal));
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void write_setting(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_CENTER:    centre_deg    = value[7:0];
            REG_AMPLITUDE: swing_deg     = value[7:0];
            REG_PHASE:     phase_inc     = value[PHASE_BITS-1:0];
            REG_SHAKE:     shake_len_s   = value[15:0];
            REG_REST:      rest_len_s    = value[15:0];
            REG_TUNE:      slew_interval = value[15:0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic motion_report_t current_report();
        motion_report_t rep;
        rep.state   = seq_state;
        rep.angle   = angle;
        rep.enabled = (seq_state == ST_SHAKE || seq_state == ST_TUNE);
        rep.steps   = steps;
        rep.cycles  = cycles;
        return rep;
    endfunction

    task automatic report_mismatch(input string note);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: MISMATCH %s", $time, note);
        end
    endtask

    task automatic compare_field(input string field, input longint unsigned got,
                                 input longint unsigned want, input logic known);
        if (!known || got != want)
        begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, field, got, want));
        end
    endtask

    task automatic check_result();
        motion_report_t want;
        if (due_reports.size() == 0)
        begin
            report_mismatch("result transfer with no command outstanding");
            return;
        end
        want = due_reports.pop_front();
        compare_field("state_code", state_code, want.state, !$isunknown(state_code));
        compare_field("servo_angle", servo_angle, want.angle, !$isunknown(servo_angle));
        compare_field("servo_enabled", servo_enabled, want.enabled,
                      !$isunknown(servo_enabled));
        compare_field("step_total", step_total, want.steps, !$isunknown(step_total));
        compare_field("cycle_total", cycle_total, want.cycles, !$isunknown(cycle_total));
        results_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_defaults();
            due_reports.delete();
            reports_due = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (cfg_valid && cfg_ready)
            begin
                write_setting(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                advance_sequencer(mode, target_angle);
                due_reports.push_back(current_report());
                states_seen[seq_state] = 1'b1;
                if (steps > peak_steps)
                begin
                    peak_steps = steps;
                end
            end
            reports_due = due_reports.size();
        end
    end

endmodule

// ===== tb/servo_oscillation_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_oscillation_sequencer_tb
// Drives commands and register settings into the sequencer with random gaps
// and output back-pressure; a side checker predicts and compares each report.
// ----------------------------------------------------------------------------
module servo_oscillation_sequencer_tb
    import sos_pkg::*;
();

    localparam int  HOLD_CYCLES  = 60;
    localparam int  DRAIN_CYCLES = 6;
    localparam real WATCHDOG_NS  = 200000.0 * 20.0;

    logic               clk = 1'b0;
    logic               rst_n;

    logic               in_valid;
    logic               in_stall;
    logic [2:0]         mode;
    logic signed [15:0] target_angle;

    logic               out_valid;
    logic               out_stall;
    logic [1:0]         state_code;
    logic [7:0]         servo_angle;
    logic               servo_enabled;
    logic [31:0]        step_total;
    logic [31:0]        cycle_total;

    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    int                 reports_due;
    int                 mismatch_count;
    int                 results_checked;
    logic [3:0]         states_seen;
    logic [31:0]        peak_steps;

    int                 idle_pct  = 38;
    int                 stall_pct = 38;
    bit                 hold_off  = 1'b0;
    int                 commands_sent = 0;
    int                 settings_used = 0;

    always #10 clk = ~clk;

    servo_oscillation_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .target_angle  (target_angle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .state_code    (state_code),
        .servo_angle   (servo_angle),
        .servo_enabled (servo_enabled),
        .step_total    (step_total),
        .cycle_total   (cycle_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sos_motion_checker motion_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .target_angle    (target_angle),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .state_code      (state_code),
        .servo_angle     (servo_angle),
        .servo_enabled   (servo_enabled),
        .step_total      (step_total),
        .cycle_total     (cycle_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .reports_due     (reports_due),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .states_seen     (states_seen),
        .peak_steps      (peak_steps)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d reports still due", reports_due);
        $display("Test completed with failures");
        $finish;
    end

    // one command transfer; random idle cycles ahead of it
    task automatic offer(input logic [2:0] cmd, input logic signed [15:0] goal);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= cmd;
        target_angle <= goal;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        commands_sent++;
    endtask

    // drop valid and wait for every outstanding report to come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_settings(input logic [7:0]  centre, input logic [7:0] swing,
                                    input logic [31:0] step, input logic [15:0] shake_s,
                                    input logic [15:0] rest_s, input logic [15:0] slew_ms);
        write_reg(REG_CENTER, 32'(centre));
        write_reg(REG_AMPLITUDE, 32'(swing));
        write_reg(REG_PHASE, step);
        write_reg(REG_SHAKE, 32'(shake_s));
        write_reg(REG_REST, 32'(rest_s));
        write_reg(REG_TUNE, 32'(slew_ms));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly ticks and tuning traffic, some raw noise on the mode field
    task automatic random_command(output logic [2:0] cmd, output logic signed [15:0] goal);
        int roll;
        roll = $urandom_range(99);
        if (roll < 62)
        begin
            cmd = MODE_TICK;
        end
        else if (roll < 67)
        begin
            cmd = MODE_START;
        end
        else if (roll < 71)
        begin
            cmd = MODE_STOP;
        end
        else if (roll < 78)
        begin
            cmd = MODE_TUNE;
        end
        else if (roll < 81)
        begin
            cmd = MODE_CLEAR;
        end
        else if (roll < 96)
        begin
            cmd = MODE_TARGET;
        end
        else
        begin
            cmd = 3'($urandom);
        end
        roll = $urandom_range(3);
        if (roll < 2)
        begin
            goal = 16'($urandom_range(ANGLE_MAX));
        end
        else if (roll == 2)
        begin
            goal = 16'($urandom_range(240)) - 16'd30;
        end
        else
        begin
            goal = 16'($urandom);
        end
    endtask

    task automatic run_phase(input int count, input bit squeeze);
        logic [2:0]         cmd;
        logic signed [15:0] goal;
        for (int i = 0; i < count; i++)
        begin
            if (squeeze && i == count / 3)
            begin
                hold_off = 1'b1;
            end
            random_command(cmd, goal);
            offer(cmd, goal);
        end
    endtask

    // a full one-second shake period into a zero-length rest and back into
    // shaking; only commands that leave the sequence alone are mixed in
    task automatic run_full_cycle();
        logic [2:0] cmd;
        offer(MODE_START, 16'sd0);
        for (int i = 0; i < 1002; i++)
        begin
            case ($urandom_range(39))
                0:       cmd = MODE_CLEAR;
                1:       cmd = MODE_TARGET;
                default: cmd = MODE_TICK;
            endcase
            if (cmd != MODE_TICK)
            begin
                offer(cmd, 16'($urandom));
            end
            offer(MODE_TICK, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_TICK;
        target_angle = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CENTER;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at power-on settings
        offer(MODE_TICK, 16'sd0);
        offer(3'(MODE_TARGET + 3'd1), 16'sd0);
        offer(3'(MODE_TARGET + 3'd2), -16'sd1);
        offer(MODE_TARGET, -16'sd32768);
        offer(MODE_STOP, 16'sd0);
        offer(MODE_TUNE, 16'sd0);
        offer(MODE_TARGET, 16'sd32767);
        offer(MODE_TARGET, -16'sd32768);
        offer(MODE_TARGET, 16'sd200);
        offer(MODE_TARGET, 16'sd45);
        offer(MODE_TICK, 16'sd0);
        offer(MODE_START, 16'sd0);
        offer(MODE_TICK, 16'sd0);
        offer(MODE_TICK, 16'sd0);
        offer(MODE_START, 16'sd0);
        offer(MODE_TICK, 16'sd0);
        offer(MODE_CLEAR, 16'sd0);
        offer(MODE_STOP, 16'sd0);
        offer(MODE_TICK, 16'sd0);
        offer(MODE_TUNE, 16'sd0);
        offer(MODE_TARGET, 16'sd0);
        offer(MODE_START, 16'sd0);
        offer(MODE_TICK, 16'sd0);
        settle();

        // zero durations and zero slew interval
        program_settings(8'd0, ANGLE_MAX, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
        run_phase(30, 1'b0);
        settle();

        // quarter-turn steps land on full scale; long output hold-off here
        program_settings(ANGLE_MAX, ANGLE_MAX, 32'h4000_0000, 16'd1, 16'd0, 16'd1);
        run_phase(50, 1'b1);
        settle();

        program_settings(ANGLE_MAX, 8'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(20, 1'b0);
        settle();

        // back-to-back transfers, no gaps on either side
        idle_pct  = 0;
        stall_pct = 0;
        program_settings(8'd90, 8'd30, 32'hFFFF_FFFF, 16'd1, 16'd1, 16'd2);
        run_phase(50, 1'b0);
        settle();
        idle_pct  = 38;
        stall_pct = 38;

        repeat (2)
        begin
            program_settings(8'($urandom_range(ANGLE_MAX)), 8'($urandom_range(ANGLE_MAX)),
                             $urandom, 16'($urandom_range(1)), 16'($urandom_range(1)),
                             16'($urandom_range(4)));
            run_phase(25, $urandom_range(1));
            settle();
        end

        program_settings(8'($urandom_range(ANGLE_MAX)), 8'($urandom_range(ANGLE_MAX)),
                         $urandom, 16'd1, 16'd0, 16'd0);
        run_full_cycle();
        settle();

        $display("Ran %0d commands through %0d register settings; %0d reports compared.",
                 commands_sent, settings_used, results_checked);
        $display("States reached (tune/rest/shake/idle) %b, peak step count %0d.",
                 states_seen, peak_steps);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
